/* design/etst_pkg.sv */
package etst_pkg;

  // default sizing
  localparam int ETST_SLOTS    = 32;
  localparam int ETST_MAX_FIRE = 8;
  localparam int ETST_GEN_BITS = 16;
  localparam int ETST_TAG_BITS = 32;

  // request kinds
  typedef enum logic [2:0] {
    REQ_ARM    = 3'd0,
    REQ_CANCEL = 3'd1,
    REQ_TICK   = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_RESET  = 3'd4
  } req_type_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  cpu;
    logic [63:0] time_ns;
    logic        callback_present;
    logic [31:0] tag;
    logic [7:0]  slot_in;
    logic [15:0] gen_in;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  slot_out;
    logic [15:0] gen_out;
    logic [31:0] fired_tag;
    logic [8:0]  count;
    logic        last;
  } out_t;

endpackage

/* design/etst_ram.sv */
module etst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/expiry_timer_slot_table.sv */
// Timer slot pool with generational handles. One request is taken at a time and the
// input stalls until its last result has been taken. Arm, cancel, query and unknown
// requests pass through decode (and the arm or cancel step) to the output wait. A tick
// scans the slot memory once per fired timer plus one final empty scan (none when
// MAX_FIRE timers fire), one slot per cycle through a single compare unit, and frees
// each winner in a fire step; each result is then read from the fired buffer and
// loaded for output. A pool reset sweeps the slot memory, stepping every generation
// and rebuilding the free list.
module expiry_timer_slot_table import etst_pkg::*; #(
  parameter int SLOTS    = ETST_SLOTS,
  parameter int MAX_FIRE = ETST_MAX_FIRE,
  parameter int GEN_BITS = ETST_GEN_BITS,
  parameter int TAG_BITS = ETST_TAG_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_res_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int FN_W  = $clog2(MAX_FIRE + 1);
  localparam int FA_W  = (MAX_FIRE > 1) ? $clog2(MAX_FIRE) : 1;
  localparam int ENT_W = GEN_BITS + 64 + TAG_BITS + IDX_W;
  localparam int BUF_W = IDX_W + TAG_BITS;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DECODE = 10'b0000000010,
    ST_ARM    = 10'b0000000100,
    ST_CANCEL = 10'b0000001000,
    ST_SCAN   = 10'b0000010000,
    ST_FIRE   = 10'b0000100000,
    ST_SWEEP  = 10'b0001000000,
    ST_OUT_RD = 10'b0010000000,
    ST_OUT_LD = 10'b0100000000,
    ST_OUT_WT = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  in_t                   req_q, req_d;
  logic [IDX_W-1:0]      free_top_q, free_top_d;
  logic [CNT_W-1:0]      live_q, live_d;
  logic [SLOTS-1:0]      armed_q, armed_d;
  logic [SLOTS-1:0]      ent_vld_q, ent_vld_d;
  logic [IDX_W:0]        scan_q, scan_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [GEN_BITS-1:0]   best_gen_q, best_gen_d;
  logic [63:0]           best_exp_q, best_exp_d;
  logic [TAG_BITS-1:0]   best_tag_q, best_tag_d;
  logic [FN_W-1:0]       fire_n_q, fire_n_d;
  logic [FN_W-1:0]       out_k_q, out_k_d;
  out_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // slot memory ports
  logic                  ent_we;
  logic [IDX_W-1:0]      ent_waddr, ent_raddr, dec_idx;
  logic [ENT_W-1:0]      ent_wdata, ent_rdata;
  // fired result buffer ports
  logic                  buf_we;
  logic [BUF_W-1:0]      buf_wdata, buf_rdata;

  // decoded slot entry
  logic [GEN_BITS-1:0]   ent_gen, gen_nx;
  logic [63:0]           ent_exp;
  logic [TAG_BITS-1:0]   ent_tag, req_tag;
  logic [IDX_W-1:0]      ent_link, dflt_link;
  logic [IDX_W:0]        idx_inc;
  logic [IDX_W-1:0]      cancel_idx;
  logic                  slot_ok;
  logic                  in_acc, out_acc;

  etst_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  etst_ram #(.WIDTH(BUF_W), .DEPTH(MAX_FIRE)) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (fire_n_q[FA_W-1:0]),
    .wdata_i (buf_wdata),
    .raddr_i (out_k_q[FA_W-1:0]),
    .rdata_o (buf_rdata)
  );

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign cancel_idx = req_q.slot_in[IDX_W-1:0];
  assign slot_ok    = (9'(req_q.slot_in) < 9'(SLOTS)) && armed_q[cancel_idx];
  assign req_tag    = TAG_BITS'(64'(req_q.tag));

  // index whose read data is being looked at
  always_comb begin
    case (state_q)
      ST_ARM:    dec_idx = free_top_q;
      ST_CANCEL: dec_idx = cancel_idx;
      default:   dec_idx = rd_idx_q;
    endcase
  end

  // entry decode: a never-written slot reads as generation zero, link to next
  assign idx_inc   = (IDX_W + 1)'(dec_idx) + 1'b1;
  assign dflt_link = (idx_inc < (IDX_W + 1)'(SLOTS)) ? idx_inc[IDX_W-1:0] : '0;
  assign ent_gen   = ent_vld_q[dec_idx] ? ent_rdata[ENT_W-1 -: GEN_BITS] : '0;
  assign ent_exp   = ent_rdata[TAG_BITS+IDX_W +: 64];
  assign ent_tag   = ent_rdata[IDX_W +: TAG_BITS];
  assign ent_link  = ent_vld_q[dec_idx] ? ent_rdata[IDX_W-1:0] : dflt_link;

  // generation step, skipping zero
  always_comb begin
    gen_nx = ent_gen + 1'b1;
    if (gen_nx == '0) begin
      gen_nx = GEN_BITS'(1);
    end
  end

  // read address: handle lookups in decode, else the scan counter
  always_comb begin
    if (state_q == ST_DECODE && req_q.req_type == REQ_ARM) begin
      ent_raddr = free_top_q;
    end else if (state_q == ST_DECODE) begin
      ent_raddr = cancel_idx;
    end else begin
      ent_raddr = scan_q[IDX_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    free_top_d  = free_top_q;
    live_d      = live_q;
    armed_d     = armed_q;
    ent_vld_d   = ent_vld_q;
    scan_d      = scan_q;
    rd_vld_d    = rd_vld_q;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_gen_d  = best_gen_q;
    best_exp_d  = best_exp_q;
    best_tag_d  = best_tag_q;
    fire_n_d    = fire_n_q;
    out_k_d     = out_k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ent_we      = 1'b0;
    ent_waddr   = dec_idx;
    ent_wdata   = {ent_gen, ent_exp, ent_tag, ent_link};
    buf_we      = 1'b0;
    buf_wdata   = {best_idx_q, best_tag_q};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d   = in_req_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        out_d       = '0;
        out_d.last  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WT;
        case (req_q.req_type)
          REQ_ARM: begin
            if (req_q.cpu == '0 && req_q.callback_present &&
                live_q < CNT_W'(SLOTS)) begin
              out_valid_d = 1'b0;
              state_d     = ST_ARM;
            end
          end
          REQ_CANCEL: begin
            if (req_q.cpu == '0 && slot_ok) begin
              out_valid_d = 1'b0;
              state_d     = ST_CANCEL;
            end
          end
          REQ_TICK: begin
            if (req_q.cpu == '0) begin
              out_valid_d = 1'b0;
              fire_n_d    = '0;
              scan_d      = '0;
              rd_vld_d    = 1'b0;
              found_d     = 1'b0;
              state_d     = ST_SCAN;
            end
          end
          REQ_QUERY: begin
            out_d.ok    = 1'b1;
            out_d.count = (req_q.cpu == '0) ? 9'(live_q) : '0;
          end
          REQ_RESET: begin
            out_valid_d = 1'b0;
            armed_d     = '0;
            free_top_d  = '0;
            live_d      = '0;
            scan_d      = '0;
            rd_vld_d    = 1'b0;
            state_d     = ST_SWEEP;
          end
          default: begin
          end
        endcase
      end

      // pop the free list head and arm it
      ST_ARM: begin
        ent_we            = 1'b1;
        ent_wdata         = {gen_nx, req_q.time_ns, req_tag, ent_link};
        ent_vld_d[dec_idx] = 1'b1;
        armed_d[dec_idx]  = 1'b1;
        live_d            = live_q + 1'b1;
        free_top_d        = ent_link;
        out_d             = '0;
        out_d.ok          = 1'b1;
        out_d.slot_out    = 8'(dec_idx);
        out_d.gen_out     = 16'(32'(gen_nx));
        out_d.last        = 1'b1;
        out_valid_d       = 1'b1;
        state_d           = ST_OUT_WT;
      end

      // generation check, then push the slot on the free list
      ST_CANCEL: begin
        out_d       = '0;
        out_d.last  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WT;
        if (32'(ent_gen) == 32'(req_q.gen_in)) begin
          ent_we           = 1'b1;
          ent_wdata        = {ent_gen, ent_exp, ent_tag, free_top_q};
          armed_d[dec_idx] = 1'b0;
          free_top_d       = dec_idx;
          if (live_q != '0) begin
            live_d = live_q - 1'b1;
          end
          out_d.ok = 1'b1;
        end
      end

      // one slot per cycle through the earliest-due compare
      ST_SCAN: begin
        if (scan_q < (IDX_W + 1)'(SLOTS)) begin
          scan_d   = scan_q + 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          if (armed_q[rd_idx_q] && ent_exp <= req_q.time_ns &&
              (!found_q || ent_exp < best_exp_q)) begin
            found_d    = 1'b1;
            best_idx_d = rd_idx_q;
            best_gen_d = ent_gen;
            best_exp_d = ent_exp;
            best_tag_d = ent_tag;
          end
        end else if (scan_q == (IDX_W + 1)'(SLOTS)) begin
          if (found_q) begin
            state_d = ST_FIRE;
          end else if (fire_n_q == '0) begin
            out_d       = '0;
            out_d.last  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_OUT_WT;
          end else begin
            out_k_d = '0;
            state_d = ST_OUT_RD;
          end
        end
      end

      // free the winner and log it
      ST_FIRE: begin
        ent_we              = 1'b1;
        ent_waddr           = best_idx_q;
        ent_wdata           = {best_gen_q, best_exp_q, best_tag_q, free_top_q};
        armed_d[best_idx_q] = 1'b0;
        free_top_d          = best_idx_q;
        if (live_q != '0) begin
          live_d = live_q - 1'b1;
        end
        buf_we   = 1'b1;
        fire_n_d = fire_n_q + 1'b1;
        if (FN_W'(fire_n_q + 1'b1) < FN_W'(MAX_FIRE)) begin
          scan_d   = '0;
          rd_vld_d = 1'b0;
          found_d  = 1'b0;
          state_d  = ST_SCAN;
        end else begin
          out_k_d = '0;
          state_d = ST_OUT_RD;
        end
      end

      // step generations and relink the free list in order
      ST_SWEEP: begin
        if (scan_q < (IDX_W + 1)'(SLOTS)) begin
          scan_d   = scan_q + 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          ent_we              = 1'b1;
          ent_wdata           = {gen_nx, ent_exp, ent_tag, dflt_link};
          ent_vld_d[rd_idx_q] = 1'b1;
        end else if (scan_q == (IDX_W + 1)'(SLOTS)) begin
          out_d       = '0;
          out_d.ok    = 1'b1;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_OUT_WT;
        end
      end

      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        out_d           = '0;
        out_d.ok        = 1'b1;
        out_d.slot_out  = 8'(buf_rdata[BUF_W-1 -: IDX_W]);
        out_d.fired_tag = 32'(64'(buf_rdata[TAG_BITS-1:0]));
        out_d.count     = 9'(fire_n_q);
        out_d.last      = (FN_W'(out_k_q + 1'b1) == fire_n_q);
        out_valid_d     = 1'b1;
        state_d         = ST_OUT_WT;
      end

      ST_OUT_WT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_q.last) begin
            state_d = ST_IDLE;
          end else begin
            out_k_d = out_k_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_top_q  <= '0;
      live_q      <= '0;
      armed_q     <= '0;
      ent_vld_q   <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      fire_n_q    <= '0;
      out_k_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_top_q  <= free_top_d;
      live_q      <= live_d;
      armed_q     <= armed_d;
      ent_vld_q   <= ent_vld_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      fire_n_q    <= fire_n_d;
      out_k_q     <= out_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_gen_q <= best_gen_d;
    best_exp_q <= best_exp_d;
    best_tag_q <= best_tag_d;
    out_q      <= out_d;
  end

  // live count tracks armed slots
  a_live_matches_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(armed_q) == int'(live_q))
    else $error("live count differs from armed slots");

  // a result is only shown in the output wait state
  a_out_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_OUT_WT)
    else $error("result valid outside output wait");

  // fired count never exceeds the limit
  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_n_q <= FN_W'(MAX_FIRE))
    else $error("too many timers fired");

  // a new request starts decoding the cycle after acceptance
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_DECODE)
    else $error("accepted request not decoded");

endmodule
